// ===== sv/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned TOP_W       = DATA_W + 1;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_LIMIT = 2'd1;

  localparam logic [DATA_W-1:0] HEAP_LIMIT_RESET = 32'd1048576;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_HEAP_EXHAUSTED = 3'd1,
    ST_TABLE_FULL     = 3'd2,
    ST_NULL_IGNORED   = 3'd3,
    ST_DOUBLE_FREE    = 3'd4,
    ST_UNKNOWN        = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_LIMIT,
    S_APPEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
    logic              is_free;
  } entry_t;

endpackage

// ===== sv/first_fit_block_allocator.sv =====
// First-fit heap block allocator: block table scan sequencer and heap bookkeeping.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in_     | input     | in_valid/in_stall  | in_command, in_request_size, in_block_address
//   out_    | output    | out_valid/out_stall| out_payload_address, out_status
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One RAM read port walks the block table; each entry is addressed in S_READ and
// compared in S_CHECK. An alloc that finds no free fit then passes S_LIMIT and, if it
// fits, S_APPEND; every result leaves through S_DONE into the output register, and a
// null free goes straight there. in_stall stays high until the return to S_IDLE.
// Reset clears the block count and heap top; the table needs no clearing pass. The
// result register lets the next request enter while an older result waits on out_stall.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [ffba_pkg::DATA_W-1:0]    in_request_size,
  input  logic [ffba_pkg::DATA_W-1:0]    in_block_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ffba_pkg::DATA_W-1:0]    out_payload_address,
  output logic [ffba_pkg::STATUS_W-1:0]  out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ffba_pkg::DATA_W-1:0]    cfg_data
);

  import ffba_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_BLOCKS);
  localparam logic [TOP_W-1:0]  HEADER_TOP = TOP_W'(HEADER_BYTES);
  localparam logic [DATA_W-1:0] HEADER_ADR = DATA_W'(HEADER_BYTES);

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [DATA_W-1:0]   req_r, req_nxt;
  logic [DATA_W-1:0]   addr_r, addr_nxt;
  logic [TOP_W-1:0]    need_r, need_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TOP_W-1:0]    heap_top_r, heap_top_nxt;
  logic [DATA_W-1:0]   heap_base_r, heap_base_nxt;
  logic [DATA_W-1:0]   heap_limit_r, heap_limit_nxt;
  logic [DATA_W-1:0]   res_addr_r, res_addr_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  entry_t              ram_wr_data;
  logic                ram_rd_en;
  entry_t              ram_rd_data;
  logic [TOP_W:0]      top_sum;
  logic [DATA_W-1:0]   new_addr;

  ffba_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;
  assign cfg_ready           = 1'b1;

  assign top_sum  = {1'b0, heap_top_r} + {1'b0, need_r};
  assign new_addr = heap_base_r + heap_top_r[DATA_W-1:0] + HEADER_ADR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      heap_top_r   <= '0;
      heap_base_r  <= '0;
      heap_limit_r <= HEAP_LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      heap_top_r   <= heap_top_nxt;
      heap_base_r  <= heap_base_nxt;
      heap_limit_r <= heap_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    need_r       <= need_nxt;
    scan_r       <= scan_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // Register writes.
  always_comb begin
    heap_base_nxt  = heap_base_r;
    heap_limit_nxt = heap_limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAP_BASE:  heap_base_nxt  = cfg_data;
        REG_HEAP_LIMIT: heap_limit_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    need_nxt       = need_r;
    scan_nxt       = scan_r;
    count_nxt      = count_r;
    heap_top_nxt   = heap_top_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = scan_r[IDX_W-1:0];
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = cmd_t'(in_command);
          req_nxt  = in_request_size;
          addr_nxt = in_block_address;
          need_nxt = HEADER_TOP + {1'b0, in_request_size};
          scan_nxt = '0;
          if (cmd_t'(in_command) == CMD_FREE && in_block_address == '0) begin
            res_addr_nxt   = '0;
            res_status_nxt = ST_NULL_IGNORED;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        if (scan_r == count_r) begin
          if (cmd_r == CMD_ALLOC) begin
            state_nxt = S_LIMIT;
          end else begin
            res_addr_nxt   = '0;
            res_status_nxt = ST_UNKNOWN;
            state_nxt      = S_DONE;
          end
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        // Write-back reuses the entry just read, with only the free mark changed.
        if (cmd_r == CMD_ALLOC) begin
          if (ram_rd_data.is_free && ram_rd_data.size >= req_r) begin
            ram_wr_en           = 1'b1;
            ram_wr_data.is_free = 1'b0;
            res_addr_nxt        = ram_rd_data.start;
            res_status_nxt      = ST_OK;
            state_nxt           = S_DONE;
          end else begin
            scan_nxt  = scan_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end else begin
          if (ram_rd_data.start == addr_r) begin
            res_addr_nxt = '0;
            if (ram_rd_data.is_free) begin
              res_status_nxt = ST_DOUBLE_FREE;
            end else begin
              ram_wr_en           = 1'b1;
              ram_wr_data.is_free = 1'b1;
              res_status_nxt      = ST_OK;
            end
            state_nxt = S_DONE;
          end else begin
            scan_nxt  = scan_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end
      end

      S_LIMIT: begin
        res_addr_nxt = '0;
        if (top_sum > {2'b00, heap_limit_r}) begin
          res_status_nxt = ST_HEAP_EXHAUSTED;
          state_nxt      = S_DONE;
        end else if (count_r == CNT_MAX) begin
          res_status_nxt = ST_TABLE_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_APPEND;
        end
      end

      S_APPEND: begin
        ram_wr_en           = 1'b1;
        ram_wr_addr         = count_r[IDX_W-1:0];
        ram_wr_data.start   = new_addr;
        ram_wr_data.size    = req_r;
        ram_wr_data.is_free = 1'b0;
        count_nxt           = count_r + CNT_W'(1);
        heap_top_nxt        = top_sum[TOP_W-1:0];
        res_addr_nxt        = new_addr;
        res_status_nxt      = ST_OK;
        state_nxt           = S_DONE;
      end

      S_DONE: begin
        // Hand the result over once the output register is empty or draining.
        if (!out_valid_r || !out_stall) begin
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ffba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ffba_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
